// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the substring search block. The clock and
// reset of the enclosing module are named clock and reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SFM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define SFM_ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

// File: rtl/sfm_pkg.sv
// ---------------------------------------------------------------------------
// Substring search package
// Sizes, register indexes and shared types of the substring search block.
// ---------------------------------------------------------------------------
package sfm_pkg;

   localparam int PATTERN_MAX    = 16;
   localparam int POSITION_BITS  = 16;
   localparam int WINDOW         = PATTERN_MAX;
   localparam int LEN_BITS       = 5;
   localparam int WIN_IDX_BITS   = 4;
   localparam int BYTE_BITS      = 8;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 64;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LEN  = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_OFFSET = 4'd3;

   typedef struct packed {
      logic                     found;
      logic [POSITION_BITS-1:0] match_position;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/sfm_front.sv
// ---------------------------------------------------------------------------
// Substring search front end
// Holds the configuration, the window of recent text bytes, the position
// counter and the done flag, and turns each accepted byte into a result
// word when it completes a match or ends a text without one.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sfm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sfm_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sfm_pkg::BYTE_BITS-1:0]         req_tdata,
   input  logic [0:0]                            req_tuser,
   input  logic                                  req_tlast,
   input  sfm_pkg::queue_status_type             queue_status,
   output logic                                  push_valid,
   output sfm_pkg::result_type                   push_data
);

   logic [sfm_pkg::CSR_DATA_BITS-1:0]       pat_low_ff;
   logic [sfm_pkg::CSR_DATA_BITS-1:0]       pat_high_ff;
   logic [sfm_pkg::LEN_BITS-1:0]            len_ff;
   logic [sfm_pkg::POSITION_BITS-1:0]       offset_ff;
   logic [sfm_pkg::BYTE_BITS-1:0]           window_ff [sfm_pkg::WINDOW];
   logic [sfm_pkg::BYTE_BITS-1:0]           window_in [sfm_pkg::WINDOW];
   logic [sfm_pkg::POSITION_BITS:0]         pos_ff;
   logic [sfm_pkg::POSITION_BITS:0]         pos_in;
   logic                                    done_ff;
   logic                                    done_in;

   logic                                    accept;
   logic [sfm_pkg::POSITION_BITS:0]         pos_cur;
   logic [sfm_pkg::POSITION_BITS:0]         pos_plus;
   logic [sfm_pkg::POSITION_BITS:0]         len_ext;
   logic [sfm_pkg::POSITION_BITS:0]         start_full;
   logic                                    done_cur;
   logic                                    len_ok;
   logic                                    in_range;
   logic                                    enough;
   logic                                    start_ok;
   logic                                    hit;
   logic                                    done_hit;
   logic [sfm_pkg::LEN_BITS-1:0]            len_m1;
   logic [sfm_pkg::BYTE_BITS*sfm_pkg::PATTERN_MAX-1:0] pattern;
   logic [sfm_pkg::WIN_IDX_BITS-1:0]        tap_idx [sfm_pkg::PATTERN_MAX];
   logic [sfm_pkg::LEN_BITS-1:0]            tap_full [sfm_pkg::PATTERN_MAX];
   logic [sfm_pkg::PATTERN_MAX-1:0]         byte_eq;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign pattern    = {pat_high_ff, pat_low_ff};
   assign len_m1     = len_ff - sfm_pkg::LEN_BITS'(1);

   always_comb begin
      window_in[0] = req_tdata;
      for (int i = 1; i < sfm_pkg::WINDOW; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   for (genvar k = 0; k < sfm_pkg::PATTERN_MAX; k++) begin : g_cmp
      assign tap_full[k] = len_m1 - sfm_pkg::LEN_BITS'(k);
      assign tap_idx[k]  = tap_full[k][sfm_pkg::WIN_IDX_BITS-1:0];
      assign byte_eq[k]  = (sfm_pkg::LEN_BITS'(k) >= len_ff)
                        || (window_in[tap_idx[k]] == pattern[sfm_pkg::BYTE_BITS*k +: 8]);
   end

   always_comb begin
      pos_cur    = req_tuser[0] ? '0 : pos_ff;
      done_cur   = req_tuser[0] ? 1'b0 : done_ff;
      pos_plus   = pos_cur + (sfm_pkg::POSITION_BITS+1)'(1);
      len_ext    = (sfm_pkg::POSITION_BITS+1)'(len_ff);
      start_full = pos_plus - len_ext;
      len_ok     = (len_ff != '0) && (len_ff <= sfm_pkg::LEN_BITS'(sfm_pkg::PATTERN_MAX));
      in_range   = !pos_cur[sfm_pkg::POSITION_BITS];
      enough     = pos_plus >= len_ext;
      start_ok   = start_full[sfm_pkg::POSITION_BITS-1:0] >= offset_ff;
      hit        = !done_cur && len_ok && in_range && enough && start_ok && (&byte_eq);
      done_hit   = done_cur || hit;
      done_in    = done_hit || req_tlast;
      pos_in     = in_range ? pos_plus : pos_cur;
      push_valid = accept && (hit || (req_tlast && !done_hit));
      push_data.found          = hit;
      push_data.match_position = hit ? start_full[sfm_pkg::POSITION_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         len_ff      <= '0;
         offset_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sfm_pkg::CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            sfm_pkg::CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            sfm_pkg::CSR_PATTERN_LEN:  len_ff      <= csr_data[sfm_pkg::LEN_BITS-1:0];
            sfm_pkg::CSR_START_OFFSET: offset_ff   <= csr_data[sfm_pkg::POSITION_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < sfm_pkg::WINDOW; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   `SFM_ASSERT_NEXT(a_hit_sets_done, push_valid && push_data.found, done_ff, "match did not close the search")
   `SFM_ASSERT(a_pos_saturates, !pos_ff[sfm_pkg::POSITION_BITS] || (pos_ff[sfm_pkg::POSITION_BITS-1:0] == '0), "position counter ran past its limit")

endmodule

// File: rtl/sfm_queue.sv
// ---------------------------------------------------------------------------
// Substring search result queue
// A short first-in first-out store of result words between the front end
// and the output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  sfm_pkg::result_type       push_data,
   input  logic                      pop,
   output sfm_pkg::result_type       head,
   output sfm_pkg::queue_status_type status
);

   sfm_pkg::result_type                   mem_ff [sfm_pkg::QUEUE_DEPTH];
   logic [sfm_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff;
   logic [sfm_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_in;
   logic [sfm_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff;
   logic [sfm_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_in;
   logic [sfm_pkg::QUEUE_CNT_BITS-1:0]    count_ff;
   logic [sfm_pkg::QUEUE_CNT_BITS-1:0]    count_in;

   assign status.full  = (count_ff == sfm_pkg::QUEUE_CNT_BITS'(sfm_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + sfm_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + sfm_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + sfm_pkg::QUEUE_CNT_BITS'(push_valid)
                - sfm_pkg::QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SFM_ASSERT(a_no_overflow, !(push_valid && status.full), "word pushed into a full queue")
   `SFM_ASSERT(a_no_underflow, !(pop && status.empty), "word popped from an empty queue")
   `SFM_ASSERT(a_count_bound, count_ff <= sfm_pkg::QUEUE_CNT_BITS'(sfm_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

// File: rtl/sfm_back.sv
// ---------------------------------------------------------------------------
// Substring search output stage
// Takes result words from the queue into an output register and presents
// them on the result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  sfm_pkg::result_type                 head,
   input  sfm_pkg::queue_status_type           queue_status,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sfm_pkg::POSITION_BITS-1:0]   rsp_tdata,
   output logic [0:0]                          rsp_tuser
);

   logic                  valid_ff;
   logic                  valid_in;
   sfm_pkg::result_type   data_ff;

   assign pop        = !queue_status.empty && (!valid_ff || rsp_tready);
   assign valid_in   = pop || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.match_position;
   assign rsp_tuser  = data_ff.found;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

   `SFM_ASSERT_NEXT(a_pop_loads, pop, valid_ff, "popped word not presented")

endmodule

// File: rtl/substring_first_match_search.sv
// A result word passes through the queue and then the output register before it shows on rsp.
// Throughput: one text byte per cycle while the queue has room; the match check is combinational.
// Byte acceptance stalls only while the four-word result queue is full.
// Reset (synchronous, active high) clears configuration, position, done flag and queue.
// After reset bytes count from position 0 as if a text had begun.
// ---------------------------------------------------------------------------
// Substring first-match search
// Streams text bytes and reports the first position at or after a start
// offset where a configured pattern of up to sixteen bytes occurs, or that none does.
// ---------------------------------------------------------------------------
module substring_first_match_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sfm_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sfm_pkg::BYTE_BITS-1:0]       req_tdata,   // text_byte
   input  logic [0:0]                          req_tuser,   // first_byte
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sfm_pkg::POSITION_BITS-1:0]   rsp_tdata,   // match_position
   output logic [0:0]                          rsp_tuser    // found
);

   logic                        push_valid;
   sfm_pkg::result_type         push_data;
   logic                        pop;
   sfm_pkg::result_type         head;
   sfm_pkg::queue_status_type   queue_status;

   sfm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   sfm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   sfm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
